// File: design/ipatv_pkg.sv
// shared types, character codes and group checks for the ip address text validator
// no dependencies
`default_nettype none

package ipatv_pkg;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_V4   = 2'd1,
        KIND_V6   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        VERDICT_NEITHER = 2'd0,
        VERDICT_V4      = 2'd1,
        VERDICT_V6      = 2'd2
    } verdict_t;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [7:0] CHAR_COLON = 8'h3a;

    localparam logic [3:0] SEP_MAX     = 4'd8;
    localparam logic [3:0] SEP_V4      = 4'd3;
    localparam logic [3:0] SEP_V6      = 4'd7;
    localparam logic [2:0] LEN_MAX     = 3'd7;
    localparam logic [2:0] LEN_V4_MAX  = 3'd3;
    localparam logic [2:0] LEN_V6_MAX  = 3'd4;
    localparam logic [9:0] DEC_MAX     = 10'd1023;
    localparam logic [9:0] OCTET_MAX   = 10'd255;

    // checks a closed group against the rules of the given address kind
    function automatic logic group_ok(
        input kind_t      kind,
        input logic [2:0] len,
        input logic [9:0] dec,
        input logic       starts_zero,
        input logic       all_dec
    );
        logic ok;
        ok = 1'b0;
        case (kind)
            KIND_V4: begin
                ok = (len != 3'd0) && (len <= LEN_V4_MAX) && all_dec
                     && (dec <= OCTET_MAX) && !(starts_zero && (len > 3'd1));
            end
            KIND_V6: begin
                ok = (len != 3'd0) && (len <= LEN_V6_MAX);
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

// File: design/ip_address_text_validator.sv
// ip address text validator: one character per transaction, one verdict per string
// depends on ipatv_pkg
// a final character passes through the input register and then the result register before its verdict appears
// throughput: one character per cycle; a final character waits in the input
//   register only while the previous verdict is still held in the result register
// reset: aresetn synchronous active low clears the valid bits of both registers and all per-string state
`default_nettype none

module ip_address_text_validator (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_char_code,
    input  wire logic                 s_is_final,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [1:0]                m_verdict
);
    import ipatv_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_final_reg;

    // per-string state
    kind_t      kind_reg, kind_next;
    logic [3:0] sep_count_reg, sep_count_next;
    logic [2:0] group_len_reg, group_len_next;
    logic [9:0] group_dec_reg, group_dec_next;
    logic       starts_zero_reg, starts_zero_next;
    logic       all_dec_reg, all_dec_next;
    logic       failed_reg, failed_next;

    // result register
    logic       m_valid_reg, m_valid_next;
    verdict_t   verdict_reg, verdict_next;

    logic       advance;
    logic       fire;
    logic       fire_final;
    logic       is_dec;
    logic       is_hex_letter;
    logic       is_sep;
    kind_t      sep_kind;
    logic [13:0] dec_sum;

    // a final character may only move on when the result register is empty or its verdict is taken in the same cycle
    assign advance    = !in_final_reg || !m_valid_reg || m_ready;
    assign fire       = in_valid_reg && advance;
    assign fire_final = fire && in_final_reg;
    assign s_ready    = !in_valid_reg || advance;

    assign is_dec        = (in_char_reg >= CHAR_ZERO) && (in_char_reg <= CHAR_NINE);
    assign is_hex_letter = ((in_char_reg >= CHAR_LO_A) && (in_char_reg <= CHAR_LO_F))
                        || ((in_char_reg >= CHAR_UP_A) && (in_char_reg <= CHAR_UP_F));
    assign is_sep        = (in_char_reg == CHAR_COLON) || (in_char_reg == CHAR_DOT);
    assign sep_kind      = (in_char_reg == CHAR_COLON) ? KIND_V6 : KIND_V4;
    // value * 10 + digit
    assign dec_sum = {1'b0, group_dec_reg, 3'b000} + {3'b000, group_dec_reg, 1'b0}
                   + {10'd0, in_char_reg[3:0]};

    always_comb begin
        kind_next        = kind_reg;
        sep_count_next   = sep_count_reg;
        group_len_next   = group_len_reg;
        group_dec_next   = group_dec_reg;
        starts_zero_next = starts_zero_reg;
        all_dec_next     = all_dec_reg;
        failed_next      = failed_reg;
        verdict_next     = VERDICT_NEITHER;

        if (fire && !failed_reg) begin
            if (is_sep) begin
                if ((kind_reg != KIND_NONE) && (kind_reg != sep_kind)) begin
                    failed_next = 1'b1;
                end else begin
                    kind_next = sep_kind;
                    if (!group_ok(sep_kind, group_len_reg, group_dec_reg,
                                  starts_zero_reg, all_dec_reg)) begin
                        failed_next = 1'b1;
                    end
                    if (sep_count_reg < SEP_MAX) begin
                        sep_count_next = sep_count_reg + 4'd1;
                    end
                    group_len_next   = 3'd0;
                    group_dec_next   = 10'd0;
                    starts_zero_next = 1'b0;
                    all_dec_next     = 1'b1;
                end
            end else if (!is_dec && !is_hex_letter) begin
                failed_next = 1'b1;
            end else begin
                if (group_len_reg == 3'd0) begin
                    starts_zero_next = (in_char_reg == CHAR_ZERO);
                end
                if (group_len_reg < LEN_MAX) begin
                    group_len_next = group_len_reg + 3'd1;
                end
                if (is_dec) begin
                    group_dec_next = (dec_sum > {4'd0, DEC_MAX}) ? DEC_MAX : dec_sum[9:0];
                end else begin
                    all_dec_next = 1'b0;
                end
            end
        end

        if (fire_final) begin
            if (!failed_next && group_ok(kind_next, group_len_next, group_dec_next,
                                         starts_zero_next, all_dec_next)) begin
                if ((kind_next == KIND_V4) && (sep_count_next == SEP_V4)) begin
                    verdict_next = VERDICT_V4;
                end else if ((kind_next == KIND_V6) && (sep_count_next == SEP_V6)) begin
                    verdict_next = VERDICT_V6;
                end
            end
            // string ends, start clean
            kind_next        = KIND_NONE;
            sep_count_next   = 4'd0;
            group_len_next   = 3'd0;
            group_dec_next   = 10'd0;
            starts_zero_next = 1'b0;
            all_dec_next     = 1'b1;
            failed_next      = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (fire_final) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            kind_reg        <= KIND_NONE;
            sep_count_reg   <= 4'd0;
            group_len_reg   <= 3'd0;
            group_dec_reg   <= 10'd0;
            starts_zero_reg <= 1'b0;
            all_dec_reg     <= 1'b1;
            failed_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            kind_reg        <= kind_next;
            sep_count_reg   <= sep_count_next;
            group_len_reg   <= group_len_next;
            group_dec_reg   <= group_dec_next;
            starts_zero_reg <= starts_zero_next;
            all_dec_reg     <= all_dec_next;
            failed_reg      <= failed_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg  <= s_char_code;
            in_final_reg <= s_is_final;
        end
        if (fire_final) begin
            verdict_reg <= verdict_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_verdict = verdict_reg;

    a_sep_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sep_count_reg <= SEP_MAX)
        else $error("separator count above saturation");

    a_clear_after_final: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_final |=> (kind_reg == KIND_NONE) && (sep_count_reg == 4'd0)
                       && (group_len_reg == 3'd0) && !failed_reg)
        else $error("per-string state not cleared after final character");

    a_final_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_final |=> m_valid_reg)
        else $error("final character produced no verdict");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !fire_final)
        else $error("pending verdict overwritten");

    a_verdict_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (verdict_reg == VERDICT_NEITHER) || (verdict_reg == VERDICT_V4)
                        || (verdict_reg == VERDICT_V6))
        else $error("verdict code out of range");

endmodule

`default_nettype wire

// File: verif/ip_address_text_validator_tb.sv
// self-checking testbench for ip_address_text_validator: directed and random address strings
// depends on ipatv_pkg and the ip_address_text_validator rtl
`default_nettype none

module ip_address_text_validator_tb;
    import ipatv_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned RANDOM_CHARS = 1100;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam string       HEX_DIGITS   = "0123456789abcdefABCDEF";
    localparam string       ADDR_SYMBOLS = "0123456789abcdefABCDEF.:";

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } addr_char_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic [7:0] s_char_code = 8'h00;
    logic       s_is_final  = 1'b0;
    logic       m_ready     = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [1:0] m_verdict;

    addr_char_t  char_q[$];
    verdict_t    verdict_q[$];
    logic [7:0]  text_buf[$];

    int unsigned errors      = 0;
    int unsigned cycle_count = 0;
    int unsigned gap_left    = 0;
    int unsigned burst_left  = 0;
    int unsigned rx_cycles   = 0;
    int unsigned hold_left   = 0;
    int unsigned rx_mode     = 0;

    // predicted per-string state
    kind_t      addr_type;
    logic [3:0] sep_seen;
    logic [2:0] grp_len;
    logic [9:0] grp_val;
    logic       grp_lead_zero;
    logic       grp_dec_only;
    logic       grp_hex_only;
    logic       str_bad;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    ip_address_text_validator uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_is_final  (s_is_final),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_verdict   (m_verdict)
    );

    function automatic void clear_group();
        grp_len       = 3'd0;
        grp_val       = 10'd0;
        grp_lead_zero = 1'b0;
        grp_dec_only  = 1'b1;
        grp_hex_only  = 1'b1;
    endfunction

    function automatic void clear_addr_state();
        addr_type = KIND_NONE;
        sep_seen  = 4'd0;
        str_bad   = 1'b0;
        clear_group();
    endfunction

    function automatic logic group_closes_ok(input kind_t k);
        logic ok;
        ok = 1'b0;
        if (grp_len != 3'd0) begin
            case (k)
                KIND_V4: begin
                    ok = (grp_len <= LEN_V4_MAX) && grp_dec_only && (grp_val <= OCTET_MAX)
                         && !(grp_lead_zero && (grp_len > 3'd1));
                end
                KIND_V6: begin
                    ok = (grp_len <= LEN_V6_MAX) && grp_hex_only;
                end
                default: begin
                    ok = 1'b0;
                end
            endcase
        end
        return ok;
    endfunction

    // advances the predicted state by one character, returns 1 when a verdict is due
    function automatic logic predict_verdict(input logic [7:0] c, input logic last,
                                             output verdict_t v);
        kind_t       sep_kind;
        logic        is_dec;
        logic        is_letter;
        int unsigned acc;
        v = VERDICT_NEITHER;
        if (!str_bad) begin
            if (c == CHAR_COLON || c == CHAR_DOT) begin
                sep_kind = (c == CHAR_COLON) ? KIND_V6 : KIND_V4;
                if (addr_type != KIND_NONE && addr_type != sep_kind) begin
                    str_bad = 1'b1;
                end else begin
                    addr_type = sep_kind;
                    if (!group_closes_ok(sep_kind))
                        str_bad = 1'b1;
                    if (sep_seen < SEP_MAX)
                        sep_seen = sep_seen + 4'd1;
                    clear_group();
                end
            end else begin
                is_dec    = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
                is_letter = ((c >= CHAR_LO_A) && (c <= CHAR_LO_F))
                            || ((c >= CHAR_UP_A) && (c <= CHAR_UP_F));
                if (!is_dec && !is_letter) begin
                    str_bad = 1'b1;
                end else begin
                    if (grp_len == 3'd0)
                        grp_lead_zero = (c == CHAR_ZERO);
                    if (grp_len < LEN_MAX)
                        grp_len = grp_len + 3'd1;
                    if (is_dec) begin
                        acc = int'(grp_val) * 10 + int'(c) - int'(CHAR_ZERO);
                        grp_val = (acc > DEC_MAX) ? DEC_MAX : acc[9:0];
                    end else begin
                        grp_dec_only = 1'b0;
                    end
                end
            end
        end
        if (!last)
            return 1'b0;
        if (!str_bad && group_closes_ok(addr_type)) begin
            if (addr_type == KIND_V4 && sep_seen == SEP_V4)
                v = VERDICT_V4;
            else if (addr_type == KIND_V6 && sep_seen == SEP_V6)
                v = VERDICT_V6;
        end
        clear_addr_state();
        return 1'b1;
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    // turns the text buffer into one string of transactions, final flag on the last
    task automatic commit_text();
        addr_char_t it;
        if (text_buf.size() == 0)
            text_buf.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < text_buf.size(); i++) begin
            it.code = text_buf[i];
            it.last = (i == text_buf.size() - 1);
            char_q.push_back(it);
        end
        text_buf.delete();
    endtask

    task automatic add_string(input string s);
        add_text(s);
        commit_text();
    endtask

    task automatic build_v4();
        int unsigned groups;
        int unsigned pick;
        groups = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 5) : 4;
        for (int g = 0; g < groups; g++) begin
            if (g != 0)
                text_buf.push_back(CHAR_DOT);
            pick = $urandom_range(0, 19);
            case (pick)
                0: add_text("255");
                1: add_text("256");
                2: add_text("0");
                3: add_text($sformatf("0%0d", $urandom_range(0, 99)));
                4: add_text($sformatf("%0d", $urandom_range(256, 9999)));
                5: add_text("");
                default: add_text($sformatf("%0d", $urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic build_v6();
        int unsigned groups;
        int unsigned glen;
        groups = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 9) : 8;
        for (int g = 0; g < groups; g++) begin
            if (g != 0)
                text_buf.push_back(CHAR_COLON);
            glen = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 1) * 5 : $urandom_range(1, 4);
            for (int i = 0; i < glen; i++)
                text_buf.push_back(HEX_DIGITS[$urandom_range(0, HEX_DIGITS.len() - 1)]);
        end
    endtask

    task automatic build_noise();
        int unsigned nlen;
        nlen = $urandom_range(1, 8);
        for (int i = 0; i < nlen; i++) begin
            if ($urandom_range(0, 1) != 0)
                text_buf.push_back(8'($urandom_range(0, 255)));
            else
                text_buf.push_back(ADDR_SYMBOLS[$urandom_range(0, ADDR_SYMBOLS.len() - 1)]);
        end
    endtask

    // replaces, deletes or inserts a character in one place, which may break a well-formed string
    task automatic corrupt_text();
        int unsigned idx;
        idx = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 3))
            0: text_buf[idx] = 8'($urandom_range(0, 255));
            1: text_buf[idx] = ($urandom_range(0, 1) != 0) ? CHAR_DOT : CHAR_COLON;
            2: if (text_buf.size() > 1) text_buf.delete(idx);
            default: text_buf.insert(idx, HEX_DIGITS[$urandom_range(0, HEX_DIGITS.len() - 1)]);
        endcase
    endtask

    // sender: bursts of transactions with random gaps
    always @(posedge aclk) begin : sender
        logic       offer;
        verdict_t   v;
        addr_char_t it;
        offer = s_valid;
        if (!aresetn) begin
            offer      = 1'b0;
            gap_left   = 0;
            burst_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                if (predict_verdict(s_char_code, s_is_final, v))
                    verdict_q.push_back(v);
                offer = 1'b0;
            end
            if (!offer) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (char_q.size() != 0) begin
                    it = char_q.pop_front();
                    s_char_code <= it.code;
                    s_is_final  <= it.last;
                    offer = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: gap_left = 0;
                            4, 5, 6, 7: gap_left = $urandom_range(1, 4);
                            8:          gap_left = $urandom_range(5, 12);
                            default:    gap_left = $urandom_range(20, 40);
                        endcase
                    end
                end
            end
        end
        s_valid <= offer;
    end

    // receiver: a randomly chosen stall pattern, plus two long hold-offs
    always @(posedge aclk) begin : receiver
        logic rdy;
        rx_cycles++;
        if (rx_cycles == 400 || rx_cycles == 1800)
            hold_left = 500;
        if (rx_cycles % 50 == 0)
            rx_mode = $urandom_range(0, 3);
        if (hold_left != 0) begin
            hold_left--;
            rdy = 1'b0;
        end else begin
            case (rx_mode)
                0:       rdy = 1'b1;
                1:       rdy = ($urandom_range(0, 1) != 0);
                2:       rdy = (rx_cycles % 4 == 0);
                default: rdy = ($urandom_range(0, 9) != 0);
            endcase
        end
        m_ready <= rdy;
    end

    always @(posedge aclk) begin : verdict_check
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $error("unexpected transaction: m_verdict actual %0d", m_verdict);
                errors++;
            end else begin
                want = verdict_q.pop_front();
                if (m_verdict !== want) begin
                    $error("m_verdict expected %0d actual %0d", want, m_verdict);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned random_chars;
        random_chars = 0;
        clear_addr_state();

        add_string("0.0.0.0");
        add_string("255.255.255.255");
        add_string("256.1.1.1");
        add_string("01.2.3.4");
        add_string("1a.2.3.4");
        add_string("1.2.3");
        add_string("1..2.3");
        add_string(".1.2.3");
        add_string("1.2.3.");
        add_string("1.2.3.4.5.6.7.8.9.0.1");
        add_string("123456789.1.1.1");
        add_string("0:0:0:0:0:0:0:0");
        add_string("ffff:FFFF:abcd:ABCD:0123:4567:89aA:bBcf");
        add_string("12345:1:1:1:1:1:1:1");
        add_string("1:2:3:4:5:6:7");
        add_string("1:2:3:4:5:6:7:8:9:a");
        add_string("1:2:3:4:5:6:7:");
        add_string("1.2:3.4");
        add_string("1:2.3:4:5:6:7:8");
        add_string("1:2:3:4:5:6:7:g");
        add_string("abc");
        add_string("1.2.3.4");
        text_buf.push_back(8'h00);
        commit_text();
        text_buf.push_back(8'hff);
        commit_text();

        // address-like strings with random content, some broken, some noise
        while (random_chars < RANDOM_CHARS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7:        build_v4();
                8, 9, 10, 11, 12, 13, 14:      build_v6();
                default:                       build_noise();
            endcase
            if (text_buf.size() != 0 && $urandom_range(0, 9) < 3)
                corrupt_text();
            random_chars += text_buf.size();
            commit_text();
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (char_q.size() != 0 || s_valid || verdict_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
